[rtl/prhmm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// prhmm_pkg: shared types and constants of the paired reading history
// Field widths, operation and register codes, and the reset values of the
// per-channel invalid readings (signed Q16.16).
// ============================================================================
package prhmm_pkg;

    // Field widths fixed by the request and result formats.
    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int CH_W     = 2;
    localparam int QIDX_W   = 6;

    // Configuration port.
    localparam int NUM_CFG   = 3;
    localparam int CFG_IDX_W = 2;

    // Channel code that never names a channel.
    localparam logic [CH_W-1:0] CH_INVALID = 2'd3;

    // Operation codes; the unused code behaves as a query.
    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_TEMPERATURE = 2'd0,
        CFG_INV_PRESSURE    = 2'd1,
        CFG_INV_HUMIDITY    = 2'd2
    } cfg_idx_t;

    // Reset values of the invalid readings: -300.0, -400.0 and -500.0.
    localparam logic [VALUE_W-1:0] INV_TEMPERATURE_RST = 32'hFED4_0000;
    localparam logic [VALUE_W-1:0] INV_PRESSURE_RST    = 32'hFE70_0000;
    localparam logic [VALUE_W-1:0] INV_HUMIDITY_RST    = 32'hFE0C_0000;

endpackage
`default_nettype wire

[rtl/prhmm_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// prhmm_if: request and result channels of the paired reading history
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ============================================================================
interface prhmm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [prhmm_pkg::OP_W-1:0]           op;
    logic [prhmm_pkg::CH_W-1:0]           channel;
    logic signed [prhmm_pkg::VALUE_W-1:0] inside_value;
    logic signed [prhmm_pkg::VALUE_W-1:0] outside_value;
    logic [prhmm_pkg::QIDX_W-1:0]         query_index;

    modport source (
        output valid, op, channel, inside_value, outside_value, query_index,
        input  ready
    );
    modport sink (
        input  valid, op, channel, inside_value, outside_value, query_index,
        output ready
    );
endinterface

// COUNT_W must equal $clog2(DEPTH + 1) of the block that drives it.
interface prhmm_out_if #(
    parameter int COUNT_W = 7
);
    logic                                 valid;
    logic                                 ready;
    logic                                 bad_channel;
    logic [COUNT_W-1:0]                   stored_count;
    logic signed [prhmm_pkg::VALUE_W-1:0] inside_at_index;
    logic signed [prhmm_pkg::VALUE_W-1:0] outside_at_index;
    logic signed [prhmm_pkg::VALUE_W-1:0] latest_inside;
    logic signed [prhmm_pkg::VALUE_W-1:0] latest_outside;
    logic signed [prhmm_pkg::VALUE_W-1:0] minimum_seen;
    logic signed [prhmm_pkg::VALUE_W-1:0] maximum_seen;

    modport source (
        output valid, bad_channel, stored_count, inside_at_index, outside_at_index,
               latest_inside, latest_outside, minimum_seen, maximum_seen,
        input  ready
    );
    modport sink (
        input  valid, bad_channel, stored_count, inside_at_index, outside_at_index,
               latest_inside, latest_outside, minimum_seen, maximum_seen,
        output ready
    );
endinterface
`default_nettype wire

[rtl/paired_reading_history_min_max_top.sv]
// A request is registered in the read stage, then in the result register.
// Throughput: one request per cycle while results are taken; the pair memory
// has one write port and two registered read ports (query slot and newest
// slot) with write bypass. Reset clears every channel's count and ring
// position, empties both pipeline stages and loads the default invalid
// readings; the pair memory is not cleared, since only slots below a
// channel's count are ever reported.
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// paired_reading_history_min_max_top: per-channel reading pair history
// Each channel keeps its newest DEPTH inside/outside pairs in a ring, plus a
// running minimum and maximum since its last clear. Every request adds,
// clears or only queries, and returns one result.
// ============================================================================
module paired_reading_history_min_max_top #(
    parameter int DEPTH    = 64,
    parameter int CHANNELS = 3
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [prhmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [prhmm_pkg::VALUE_W-1:0]         cfg_data,
    prhmm_in_if.sink                                   req,
    prhmm_out_if.source                                rsp
);

    localparam int VW   = prhmm_pkg::VALUE_W;
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW   = (CHANNELS * DEPTH > 1) ? $clog2(CHANNELS * DEPTH) : 1;
    localparam int SW   = ((PW > prhmm_pkg::QIDX_W) ? PW : prhmm_pkg::QIDX_W) + 1;

    // Side data that travels with the memory read to the output stage.
    typedef struct packed {
        logic                 bad;
        logic                 q_hit;
        logic                 nonempty;
        logic [CNTW-1:0]      cnt;
        logic signed [VW-1:0] inv;
        logic signed [VW-1:0] min;
        logic signed [VW-1:0] max;
    } s1_t;

    typedef struct packed {
        logic                 bad;
        logic [CNTW-1:0]      cnt;
        logic signed [VW-1:0] q_in;
        logic signed [VW-1:0] q_out;
        logic signed [VW-1:0] l_in;
        logic signed [VW-1:0] l_out;
        logic signed [VW-1:0] min;
        logic signed [VW-1:0] max;
    } res_t;

    // Reduce a ring position below twice the depth into the ring.
    function automatic logic [PW-1:0] wrap_pos(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[PW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [VW-1:0]         inv_reg    [prhmm_pkg::NUM_CFG];
    logic [CNTW-1:0]       count_reg  [CHANNELS];
    logic [PW-1:0]         oldest_reg [CHANNELS];
    logic signed [VW-1:0]  min_reg    [CHANNELS];
    logic signed [VW-1:0]  max_reg    [CHANNELS];
    logic [2*VW-1:0]       pair_mem   [CHANNELS*DEPTH];

    logic                  s1_valid_reg;
    s1_t                   s1_reg;
    logic [2*VW-1:0]       q_rd_reg;
    logic [2*VW-1:0]       l_rd_reg;
    logic                  out_valid_reg;
    res_t                  out_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic out_free;
    logic s1_adv;
    logic req_fire;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign req_fire  = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg[0] <= prhmm_pkg::INV_TEMPERATURE_RST;
            inv_reg[1] <= prhmm_pkg::INV_PRESSURE_RST;
            inv_reg[2] <= prhmm_pkg::INV_HUMIDITY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prhmm_pkg::CFG_INV_TEMPERATURE: inv_reg[0] <= cfg_data;
                prhmm_pkg::CFG_INV_PRESSURE:    inv_reg[1] <= cfg_data;
                prhmm_pkg::CFG_INV_HUMIDITY:    inv_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Request decode and channel state update
    // ------------------------------------------------------------------
    logic                 bad;
    logic [CW-1:0]        chi;
    logic [VW-1:0]        inv_sel;
    logic [CNTW-1:0]      cnt_cur;
    logic [PW-1:0]        old_cur;
    logic                 full;
    logic                 do_add;
    logic [CNTW-1:0]      count_next;
    logic [PW-1:0]        oldest_next;
    logic [PW-1:0]        wpos;
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] min_next;
    logic signed [VW-1:0] max_next;
    logic [PW-1:0]        qpos;
    logic [PW-1:0]        lpos;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        qaddr;
    logic [AW-1:0]        laddr;
    logic [2*VW-1:0]      wdata;
    logic                 wr_en;

    assign bad     = (req.channel == prhmm_pkg::CH_INVALID) ||
                     ({{(32-prhmm_pkg::CH_W){1'b0}}, req.channel} >= 32'(CHANNELS));
    assign chi     = bad ? '0 : CW'(req.channel);
    assign inv_sel = (req.channel == prhmm_pkg::CH_INVALID) ? '0 : inv_reg[req.channel];
    assign cnt_cur = count_reg[chi];
    assign old_cur = oldest_reg[chi];
    assign full    = (cnt_cur == CNTW'(DEPTH));
    assign do_add  = (req.op == prhmm_pkg::OP_ADD);

    // Smaller and larger reading of the incoming pair.
    assign lo = (req.outside_value < req.inside_value) ? req.outside_value : req.inside_value;
    assign hi = (req.inside_value < req.outside_value) ? req.outside_value : req.inside_value;

    always_comb
    begin
        count_next  = cnt_cur;
        oldest_next = old_cur;
        wpos        = wrap_pos(SW'(old_cur) + SW'(cnt_cur));
        min_next    = min_reg[chi];
        max_next    = max_reg[chi];
        case (req.op)
            prhmm_pkg::OP_ADD:
            begin
                if (full)
                begin
                    // Overwrite the oldest pair and move the ring start.
                    wpos        = old_cur;
                    oldest_next = (old_cur == PW'(DEPTH - 1)) ? '0 : old_cur + 1'b1;
                end
                else
                begin
                    count_next = cnt_cur + 1'b1;
                end
                if (cnt_cur == '0)
                begin
                    min_next = lo;
                    max_next = hi;
                end
                else
                begin
                    if (lo < min_reg[chi])
                        min_next = lo;
                    if (max_reg[chi] < hi)
                        max_next = hi;
                end
            end
            prhmm_pkg::OP_CLEAR:
            begin
                count_next  = '0;
                oldest_next = '0;
            end
            default: ;
        endcase
    end

    // Read positions use the state after this request.
    assign qpos  = wrap_pos(SW'(oldest_next) + SW'(req.query_index));
    assign lpos  = wrap_pos(SW'(oldest_next) + SW'(count_next) - 1'b1);
    assign waddr = AW'(chi) * AW'(DEPTH) + AW'(wpos);
    assign qaddr = AW'(chi) * AW'(DEPTH) + AW'(qpos);
    assign laddr = AW'(chi) * AW'(DEPTH) + AW'(lpos);
    assign wdata = {req.inside_value, req.outside_value};
    assign wr_en = req_fire && do_add && !bad;

    // Count and ring start per channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                count_reg[c]  <= '0;
                oldest_reg[c] <= '0;
            end
        end
        else if (req_fire && !bad)
        begin
            count_reg[chi]  <= count_next;
            oldest_reg[chi] <= oldest_next;
        end
    end

    // Running extremes; meaningful only while the count is nonzero.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            min_reg[chi] <= min_next;
            max_reg[chi] <= max_next;
        end
    end

    // ------------------------------------------------------------------
    // Pair memory: one write, two registered reads with write bypass
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
            pair_mem[waddr] <= wdata;
        if (req_fire)
        begin
            q_rd_reg <= (wr_en && (waddr == qaddr)) ? wdata : pair_mem[qaddr];
            l_rd_reg <= (wr_en && (waddr == laddr)) ? wdata : pair_mem[laddr];
        end
    end

    // ------------------------------------------------------------------
    // Read stage side data
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_fire)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_reg.bad      <= bad;
            s1_reg.q_hit    <= (SW'(req.query_index) < SW'(count_next));
            s1_reg.nonempty <= (count_next != '0);
            s1_reg.cnt      <= count_next;
            s1_reg.inv      <= inv_sel;
            s1_reg.min      <= min_next;
            s1_reg.max      <= max_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    res_t res_next;

    always_comb
    begin
        res_next.bad   = s1_reg.bad;
        res_next.cnt   = s1_reg.cnt;
        res_next.q_in  = s1_reg.q_hit ? q_rd_reg[2*VW-1:VW] : s1_reg.inv;
        res_next.q_out = s1_reg.q_hit ? q_rd_reg[VW-1:0] : s1_reg.inv;
        res_next.l_in  = s1_reg.nonempty ? l_rd_reg[2*VW-1:VW] : s1_reg.inv;
        res_next.l_out = s1_reg.nonempty ? l_rd_reg[VW-1:0] : s1_reg.inv;
        res_next.min   = s1_reg.nonempty ? s1_reg.min : s1_reg.inv;
        res_next.max   = s1_reg.nonempty ? s1_reg.max : s1_reg.inv;
        // A bad channel reports only its flag.
        if (s1_reg.bad)
        begin
            res_next     = '0;
            res_next.bad = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
            out_reg <= res_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.bad_channel      = out_reg.bad;
    assign rsp.stored_count     = out_reg.cnt;
    assign rsp.inside_at_index  = out_reg.q_in;
    assign rsp.outside_at_index = out_reg.q_out;
    assign rsp.latest_inside    = out_reg.l_in;
    assign rsp.latest_outside   = out_reg.l_out;
    assign rsp.minimum_seen     = out_reg.min;
    assign rsp.maximum_seen     = out_reg.max;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // No request may enter while both stages hold a result that cannot move.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !rsp.ready) |-> !req_fire)
        else $error("request accepted into a blocked pipeline");

    // An accepted add on a good channel leaves a nonempty channel behind.
    a_add_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && do_add && !bad) |=> (s1_valid_reg && s1_reg.nonempty))
        else $error("add left the channel empty");

    // The running minimum never exceeds the running maximum.
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.bad_channel && (rsp.stored_count != '0)) |->
        (rsp.minimum_seen <= rsp.maximum_seen))
        else $error("minimum above maximum");

    // A result moves to the output register only when the read stage holds one.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(s1_valid_reg))
        else $error("result appeared without a read stage entry");

endmodule
`default_nettype wire
